/* hw/rtl/svlq_pkg.sv */
// ----------------------------------------------------------------------------
// svlq_pkg
// Shared types and helpers for the signed variable-length integer codec.
// ----------------------------------------------------------------------------
package svlq_pkg;

	// index of the most significant 7-bit group, 0..4
	typedef logic [2:0] grp_t;

	// commands from controller to datapath
	typedef struct packed {
		logic enc_start; // accept an encode item and emit its first byte
		logic enc_next;  // emit the next byte of the held word
		logic dec_byte;  // accept a decode item
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic more;      // the byte being emitted is not the last one
		logic out_busy;  // output register holds an item that is stalled
	} sts_t;

	localparam grp_t GRP_ONE   = 3'd0;
	localparam grp_t GRP_TWO   = 3'd1;
	localparam grp_t GRP_THREE = 3'd2;
	localparam grp_t GRP_FOUR  = 3'd3;
	localparam grp_t GRP_FIVE  = 3'd4;

	localparam logic signed [31:0] LO_1 = -32'sd32;
	localparam logic signed [31:0] HI_1 = 32'sd96;
	localparam logic signed [31:0] LO_2 = -32'sd4096;
	localparam logic signed [31:0] HI_2 = 32'sd12288;
	localparam logic signed [31:0] LO_3 = -32'sd524288;
	localparam logic signed [31:0] HI_3 = 32'sd1572864;
	localparam logic signed [31:0] LO_4 = -32'sd67108864;
	localparam logic signed [31:0] HI_4 = 32'sd201326592;

	// top group index of the shortest encoding whose signed range holds the word
	function automatic grp_t top_group(input logic [31:0] word);
		logic signed [31:0] s;
		s = $signed(word);
		if (s >= LO_1 && s < HI_1)
			top_group = GRP_ONE;
		else if (s >= LO_2 && s < HI_2)
			top_group = GRP_TWO;
		else if (s >= LO_3 && s < HI_3)
			top_group = GRP_THREE;
		else if (s >= LO_4 && s < HI_4)
			top_group = GRP_FOUR;
		else
			top_group = GRP_FIVE;
	endfunction

endpackage

/* hw/rtl/svlq_ctrl.sv */
// ----------------------------------------------------------------------------
// svlq_ctrl
// Controller: input handshake and the byte-emission sequence of an encode.
// ----------------------------------------------------------------------------
module svlq_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_stall,
	input  logic           mode,
	input  svlq_pkg::sts_t sts,
	output svlq_pkg::cmd_t cmd
);
	import svlq_pkg::*;

	localparam logic ST_IDLE = 1'b0;
	localparam logic ST_ENC  = 1'b1;

	logic state_q;
	logic state_d;
	logic accept;

	// hold input while emitting trailing bytes or while the output is stalled
	assign in_stall = (state_q == ST_ENC) || sts.out_busy;
	assign accept   = in_valid && !in_stall;

	// commands
	assign cmd.enc_start = accept && !mode;
	assign cmd.dec_byte  = accept && mode;
	assign cmd.enc_next  = (state_q == ST_ENC) && !sts.out_busy;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (cmd.enc_start && sts.more)
					state_d = ST_ENC;
			end
			ST_ENC: begin
				if (cmd.enc_next && !sts.more)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

endmodule

/* hw/rtl/svlq_dp.sv */
// ----------------------------------------------------------------------------
// svlq_dp
// Datapath: held word and group counter, decode accumulator, output register.
// ----------------------------------------------------------------------------
module svlq_dp (
	input  logic           clk,
	input  logic           arst_n,
	input  svlq_pkg::cmd_t cmd,
	output svlq_pkg::sts_t sts,
	input  logic [31:0]    value,
	input  logic [7:0]     byte_in,
	output logic           out_valid,
	input  logic           out_stall,
	output logic           kind,
	output logic [7:0]     byte_out,
	output logic           last,
	output logic [31:0]    value_out
);
	import svlq_pkg::*;

	logic [31:0] word_q;
	grp_t        grp_q;
	logic [31:0] acc_q;
	logic        first_q;
	logic        out_valid_q;
	logic        kind_q;
	logic [7:0]  byte_q;
	logic        last_q;
	logic [31:0] value_q;

	logic [31:0] word_sel;
	grp_t        grp_sel;
	logic [6:0]  group_bits;
	logic        enc_emit;
	logic [31:0] dec_val;
	logic        dec_emit;
	logic        sext;

	// encode: pick the word and group for the byte going out now
	assign enc_emit = cmd.enc_start || cmd.enc_next;
	assign word_sel = cmd.enc_start ? value : word_q;
	assign grp_sel  = cmd.enc_start ? top_group(value) : grp_q;

	always_comb begin
		case (grp_sel)
			GRP_ONE:   group_bits = word_sel[6:0];
			GRP_TWO:   group_bits = word_sel[13:7];
			GRP_THREE: group_bits = word_sel[20:14];
			GRP_FOUR:  group_bits = word_sel[27:21];
			GRP_FIVE:  group_bits = {3'b000, word_sel[31:28]};
			default:   group_bits = 7'd0;
		endcase
	end

	// decode: sign-extend a first byte, otherwise shift in seven bits
	assign sext     = byte_in[6] && byte_in[5];
	assign dec_val  = first_q ? {{25{sext}}, byte_in[6:0]} : {acc_q[24:0], byte_in[6:0]};
	assign dec_emit = cmd.dec_byte && !byte_in[7];

	assign sts.more     = (grp_sel != GRP_ONE);
	assign sts.out_busy = out_valid_q && out_stall;

	// held word and remaining groups
	always_ff @(posedge clk) begin
		if (enc_emit) begin
			word_q <= word_sel;
			grp_q  <= grp_sel - 3'd1;
		end
	end

	// decode state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q   <= 32'd0;
			first_q <= 1'b1;
		end else if (cmd.dec_byte) begin
			if (byte_in[7]) begin
				acc_q   <= dec_val;
				first_q <= 1'b0;
			end else begin
				acc_q   <= 32'd0;
				first_q <= 1'b1;
			end
		end
	end

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (enc_emit || dec_emit)
			out_valid_q <= 1'b1;
		else if (!out_stall)
			out_valid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (enc_emit) begin
			kind_q  <= 1'b0;
			byte_q  <= {(grp_sel != GRP_ONE), group_bits};
			last_q  <= (grp_sel == GRP_ONE);
			value_q <= 32'd0;
		end else if (dec_emit) begin
			kind_q  <= 1'b1;
			byte_q  <= 8'd0;
			last_q  <= 1'b1;
			value_q <= dec_val;
		end
	end

	assign out_valid = out_valid_q;
	assign kind      = kind_q;
	assign byte_out  = byte_q;
	assign last      = last_q;
	assign value_out = value_q;

endmodule

/* hw/rtl/signed_vlq_integer_codec.sv */
// ----------------------------------------------------------------------------
// signed_vlq_integer_codec
// Signed variable-length integer codec: encodes a 32-bit word into 1 to 5
// bytes, or decodes one byte per item into a 32-bit word.
// The output register takes the first result of an accepted item in the next cycle.
// Decode takes an item each cycle unless an encode is emitting or the output stalls;
// an encode holds the input while the byte sequencer feeds the single output register.
// Reset: arst_n clears the controller, output valid and the decode state.
// ----------------------------------------------------------------------------
module signed_vlq_integer_codec (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        mode,
	input  logic [31:0] value,
	input  logic [7:0]  byte_in,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        kind,
	output logic [7:0]  byte_out,
	output logic        last,
	output logic [31:0] value_out
);
	import svlq_pkg::*;

	cmd_t cmd;
	sts_t sts;

	// controller
	svlq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.mode     (mode),
		.sts      (sts),
		.cmd      (cmd)
	);

	// datapath
	svlq_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.value     (value),
		.byte_in   (byte_in),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.byte_out  (byte_out),
		.last      (last),
		.value_out (value_out)
	);

endmodule
